// ===== design/assert_macros.svh =====
// Assertion helpers for the alarm zone arming controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AZAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication.
`define AZAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/azac_pkg.sv =====
package azac_pkg;

    localparam int NUM_ZONES_DEF = 8;
    localparam int NUM_KEYS_DEF  = 4;

    localparam int SAMPLE_ZONES = 8;
    localparam int SAMPLE_KEYS  = 4;
    localparam int FN_ZONES     = 8;

    localparam int APB_AW = 3;
    localparam logic REG_ZONE_FN = 1'b0;
    localparam logic REG_THR     = 1'b1;

    localparam logic [3:0] THR_RESET = 4'd8;

    localparam logic [2:0] FN_OFF       = 3'd0;
    localparam logic [2:0] FN_PERIMETER = 3'd1;
    localparam logic [2:0] FN_INTERIOR  = 3'd2;
    localparam logic [2:0] FN_ALWAYS    = 3'd3;
    localparam logic [2:0] FN_DELAYED   = 3'd4;

    localparam int KEY_AWAY   = 0;
    localparam int KEY_HOME   = 1;
    localparam int KEY_DISARM = 2;

    localparam logic [1:0] BLINK_OFF  = 2'd0;
    localparam logic [1:0] BLINK_SLOW = 2'd1;
    localparam logic [1:0] BLINK_FAST = 2'd2;

    typedef enum logic [2:0] {
        ST_DISARMED  = 3'd0,
        ST_HOME      = 3'd1,
        ST_AWAY      = 3'd2,
        ST_PENDING   = 3'd3,
        ST_TRIGGERED = 3'd4
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [2:0] state;
    } t_cmd;

    typedef struct packed {
        logic [2:0] state;
        logic [2:0] cause;
        logic       siren;
        logic [1:0] blink;
        logic       beep;
        logic       notify;
        logic       state_changed;
    } t_status;

    typedef struct packed {
        logic [3:0] pad;
        logic [2:0] command_state;
        logic       command_valid;
        logic [3:0] rf_second;
        logic [3:0] rf_first;
        logic [7:0] zone_second;
        logic [7:0] zone_first;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] pad;
        logic       inputs_changed;
        logic       state_changed;
        logic       notify_pulse;
        logic       beep_pulse;
        logic [1:0] blink_mode;
        logic       siren_on;
        logic [3:0] rf_levels;
        logic [7:0] zone_levels;
        logic [2:0] trip_zone;
        logic [2:0] alarm_state;
    } t_out_beat;

endpackage

// ===== design/azac_lane.sv =====
module azac_lane (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [3:0] i_thr,
    input  logic       i_first,
    input  logic       i_second,
    output logic       o_accept,
    output logic       o_level_next
);

    logic       r_level;
    logic [3:0] r_count;
    logic       n_level;
    logic [3:0] n_count;
    logic       w_acc;

    always_comb begin
        n_level = r_level;
        n_count = r_count;
        w_acc   = 1'b0;
        if (i_first != r_level) begin
            if (i_second != r_level) begin
                n_count = (r_count == 4'hF) ? r_count : r_count + 4'd1;
            end else begin
                n_count = 4'd0;
            end
            if (n_count >= i_thr) begin
                n_level = i_second;
                n_count = 4'd0;
                w_acc   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b1;
            r_count <= 4'd0;
        end else if (i_en) begin
            r_level <= n_level;
            r_count <= n_count;
        end
    end

    assign o_accept     = w_acc;
    assign o_level_next = n_level;

endmodule

// ===== design/azac_merge.sv =====
module azac_merge #(
    parameter int NUM_ZONES = azac_pkg::NUM_ZONES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  azac_pkg::t_cmd        i_cmd,
    input  logic [23:0]           i_zone_fn,
    input  logic [NUM_ZONES-1:0]  i_zone_acc,
    input  logic [NUM_ZONES-1:0]  i_zone_new,
    input  logic [2:0]            i_key_acc,
    output azac_pkg::t_status     o_status
);

    azac_pkg::t_state r_state, n_state;
    logic [2:0]       r_cause, n_cause;
    logic             r_siren, n_siren;
    logic [1:0]       r_blink, n_blink;
    logic             w_beep, w_notify, w_changed;
    logic [2:0]       w_fn [NUM_ZONES];
    logic [NUM_ZONES-1:0] w_trig;

    // zones beyond the function register act as off
    for (genvar g = 0; g < NUM_ZONES; g++) begin : g_fn
        if (g < azac_pkg::FN_ZONES) begin : g_cfg
            assign w_fn[g] = i_zone_fn[3*g +: 3];
        end else begin : g_off
            assign w_fn[g] = azac_pkg::FN_OFF;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_ZONES; i++) begin
            case (w_fn[i])
                azac_pkg::FN_PERIMETER:
                    w_trig[i] = i_zone_acc[i] &&
                                (r_state == azac_pkg::ST_HOME || r_state == azac_pkg::ST_AWAY);
                azac_pkg::FN_INTERIOR:
                    w_trig[i] = i_zone_acc[i] && (r_state == azac_pkg::ST_AWAY);
                azac_pkg::FN_ALWAYS:
                    w_trig[i] = i_zone_acc[i] && i_zone_new[i];
                default:
                    w_trig[i] = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cause   = r_cause;
        n_siren   = r_siren;
        n_blink   = r_blink;
        w_beep    = 1'b0;
        w_notify  = 1'b0;
        w_changed = 1'b0;

        if (i_cmd.valid && i_cmd.state <= azac_pkg::ST_TRIGGERED) begin
            n_state = azac_pkg::t_state'(i_cmd.state);
        end
        for (int i = 0; i < NUM_ZONES; i++) begin
            if (w_trig[i]) begin
                n_state = azac_pkg::ST_TRIGGERED;
                n_cause = 3'(i);
            end
        end
        if (i_key_acc[azac_pkg::KEY_AWAY])   n_state = azac_pkg::ST_AWAY;
        if (i_key_acc[azac_pkg::KEY_HOME])   n_state = azac_pkg::ST_HOME;
        if (i_key_acc[azac_pkg::KEY_DISARM]) n_state = azac_pkg::ST_DISARMED;

        if (n_state != r_state) begin
            w_changed = 1'b1;
            case (n_state)
                azac_pkg::ST_DISARMED: begin
                    n_siren = 1'b0;
                    n_blink = azac_pkg::BLINK_OFF;
                    if (r_state == azac_pkg::ST_AWAY) begin
                        w_beep   = 1'b1;
                        w_notify = 1'b1;
                    end
                end
                azac_pkg::ST_HOME: begin
                    n_blink = azac_pkg::BLINK_SLOW;
                end
                azac_pkg::ST_AWAY: begin
                    n_blink  = azac_pkg::BLINK_SLOW;
                    w_beep   = 1'b1;
                    w_notify = 1'b1;
                end
                azac_pkg::ST_TRIGGERED: begin
                    n_siren  = 1'b1;
                    n_blink  = azac_pkg::BLINK_FAST;
                    w_notify = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= azac_pkg::ST_DISARMED;
            r_cause <= 3'd0;
            r_siren <= 1'b0;
            r_blink <= azac_pkg::BLINK_OFF;
        end else if (i_en) begin
            r_state <= n_state;
            r_cause <= n_cause;
            r_siren <= n_siren;
            r_blink <= n_blink;
        end
    end

    assign o_status.state         = n_state;
    assign o_status.cause         = n_cause;
    assign o_status.siren         = n_siren;
    assign o_status.blink         = n_blink;
    assign o_status.beep          = w_beep;
    assign o_status.notify        = w_notify;
    assign o_status.state_changed = w_changed;

endmodule

// ===== design/alarm_zone_arming_controller_core.sv =====
// Alarm zone arming controller.
// s_axis carries one poll tick per beat: two samples of the zone lines and of
// the remote-key lines plus an optional remote arm command. Each line has its
// own debounce lane; a merge stage resolves trigger, key and command requests
// and applies the resulting state entry.
// m_axis returns one status beat per input beat, in order.
// Throughput: one beat per cycle while s_axis_tready is high; all lanes and the
// merge finish in the accept cycle; the status beat is registered.
// Stall: an output register plus a one-beat skid stage; s_axis_tready drops
// only while both hold a result the receiver has not taken.
// Configuration: APB, zone functions at 0x0, debounce threshold at 0x4. Users
// write them only while the stream is idle (not enforced); pready is tied high.
// Reset (synchronous, active low): all lines open, counts zero, disarmed,
// siren and indicator off, threshold 8, all zones off, no beat pending.
module alarm_zone_arming_controller_core #(
    parameter int NUM_ZONES = azac_pkg::NUM_ZONES_DEF,
    parameter int NUM_KEYS  = azac_pkg::NUM_KEYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // zone_first, zone_second, rf_first, rf_second, command_valid, command_state
    input  logic [31:0]                 s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // alarm_state, trip_zone, zone_levels, rf_levels, siren_on, blink_mode,
    // beep_pulse, notify_pulse, state_changed, inputs_changed
    output logic [31:0]                 m_axis_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [azac_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    azac_pkg::t_in_beat  w_in;
    azac_pkg::t_out_beat w_res;
    azac_pkg::t_out_beat r_od, r_sd;
    azac_pkg::t_status   w_status;
    azac_pkg::t_cmd      w_cmd;
    logic                r_ov, r_sv;
    logic [23:0]         r_zone_fn;
    logic [3:0]          r_thr;
    logic [3:0]          w_thr;
    logic                w_acc;
    logic [NUM_ZONES-1:0] w_zone_acc, w_zone_new;
    logic [NUM_KEYS-1:0]  w_key_acc, w_key_new;
    logic [7:0]          w_zl;
    logic [3:0]          w_rl;
    logic                w_od_trig;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_fn <= 24'd0;
            r_thr     <= azac_pkg::THR_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                azac_pkg::REG_ZONE_FN: r_zone_fn <= pwdata[23:0];
                azac_pkg::REG_THR:     r_thr     <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            azac_pkg::REG_ZONE_FN: prdata = {8'd0, r_zone_fn};
            azac_pkg::REG_THR:     prdata = {28'd0, r_thr};
            default:               prdata = 32'd0;
        endcase
    end

    assign w_thr = (r_thr == 4'd0) ? 4'd1 : r_thr;

    assign w_in          = azac_pkg::t_in_beat'(s_axis_tdata);
    assign s_axis_tready = !r_sv;
    assign w_acc         = s_axis_tvalid && !r_sv;

    // lines past the sample width read as 0
    for (genvar g = 0; g < NUM_ZONES; g++) begin : g_zone
        logic w_a, w_b;
        if (g < azac_pkg::SAMPLE_ZONES) begin : g_in
            assign w_a = w_in.zone_first[g];
            assign w_b = w_in.zone_second[g];
        end else begin : g_zero
            assign w_a = 1'b0;
            assign w_b = 1'b0;
        end
        azac_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (w_acc),
            .i_thr        (w_thr),
            .i_first      (w_a),
            .i_second     (w_b),
            .o_accept     (w_zone_acc[g]),
            .o_level_next (w_zone_new[g])
        );
    end

    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
        logic w_a, w_b;
        if (g < azac_pkg::SAMPLE_KEYS) begin : g_in
            assign w_a = w_in.rf_first[g];
            assign w_b = w_in.rf_second[g];
        end else begin : g_zero
            assign w_a = 1'b0;
            assign w_b = 1'b0;
        end
        azac_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (w_acc),
            .i_thr        (w_thr),
            .i_first      (w_a),
            .i_second     (w_b),
            .o_accept     (w_key_acc[g]),
            .o_level_next (w_key_new[g])
        );
    end

    assign w_cmd.valid = w_in.command_valid;
    assign w_cmd.state = w_in.command_state;

    azac_merge #(
        .NUM_ZONES (NUM_ZONES)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_acc),
        .i_cmd      (w_cmd),
        .i_zone_fn  (r_zone_fn),
        .i_zone_acc (w_zone_acc),
        .i_zone_new (w_zone_new),
        .i_key_acc  (w_key_acc[2:0]),
        .o_status   (w_status)
    );

    always_comb begin
        w_zl = 8'd0;
        w_rl = 4'd0;
        for (int i = 0; i < NUM_ZONES; i++) begin
            if (i < 8) w_zl[i[2:0]] = w_zone_new[i];
        end
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (i < 4) w_rl[i[1:0]] = w_key_new[i];
        end
    end

    always_comb begin
        w_res                = '0;
        w_res.alarm_state    = w_status.state;
        w_res.trip_zone      = w_status.cause;
        w_res.zone_levels    = w_zl;
        w_res.rf_levels      = w_rl;
        w_res.siren_on       = w_status.siren;
        w_res.blink_mode     = w_status.blink;
        w_res.beep_pulse     = w_status.beep;
        w_res.notify_pulse   = w_status.notify;
        w_res.state_changed  = w_status.state_changed;
        w_res.inputs_changed = (|w_zone_acc) || (|w_key_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (m_axis_tready) begin
                r_sv <= 1'b0;
            end
        end else if (w_acc && r_ov && !m_axis_tready) begin
            r_sv <= 1'b1;
        end else if (w_acc) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv && m_axis_tready) begin
            r_od <= r_sd;
        end else if (w_acc && (!r_ov || m_axis_tready)) begin
            r_od <= w_res;
        end
        if (w_acc && r_ov && !m_axis_tready) begin
            r_sd <= w_res;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

    assign w_od_trig = (r_od.alarm_state == azac_pkg::ST_TRIGGERED);

    `include "assert_macros.svh"

    `AZAC_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_sv, r_ov)
    `AZAC_ASSERT_NXT(a_skid_drains_to_out, i_clk, i_rst_n, r_sv, r_ov)
    `AZAC_ASSERT_IMP(a_beep_change, i_clk, i_rst_n, r_ov && r_od.beep_pulse, r_od.state_changed)
    `AZAC_ASSERT_IMP(a_triggered_siren, i_clk, i_rst_n, m_axis_tvalid && w_od_trig, r_od.siren_on)

endmodule

// ===== tb/alarm_zone_arming_controller_core_test.sv =====
module alarm_zone_arming_controller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FN_SPARE_LO  = 3'd5;
    localparam logic [2:0] FN_SPARE_MID = 3'd6;
    localparam logic [2:0] FN_SPARE_HI  = 3'd7;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    azac_pkg::t_in_beat s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [azac_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    alarm_zone_arming_controller_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // zone_first, zone_second, rf_first, rf_second, command_valid, command_state
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // alarm_state, trip_zone, zone_levels, rf_levels, siren_on, blink_mode,
        // beep_pulse, notify_pulse, state_changed, inputs_changed
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    // alarm model state
    logic [23:0]                          zone_fn;
    logic [3:0]                           thr_reg;
    logic [azac_pkg::NUM_ZONES_DEF-1:0]   zone_lvl;
    logic [3:0]                           zone_cnt [azac_pkg::NUM_ZONES_DEF];
    logic [azac_pkg::NUM_KEYS_DEF-1:0]    key_lvl;
    logic [3:0]                           key_cnt [azac_pkg::NUM_KEYS_DEF];
    azac_pkg::t_state                     cur_st;
    azac_pkg::t_state                     req_st;
    logic [2:0]                           cause_zone;
    logic                                 siren_lvl;
    logic [1:0]                           blink_md;

    azac_pkg::t_out_beat expected_status [$];
    int        mismatches = 0;
    logic      no_idle = 1'b0;
    logic      hold_active = 1'b0;
    event      hold_out;

    // physical line levels for the random stimulus
    logic [7:0] line_zone;
    logic [3:0] line_key;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 60)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic model_reset();
        zone_fn    = '0;
        thr_reg    = azac_pkg::THR_RESET;
        zone_lvl   = '1;
        key_lvl    = '1;
        zone_cnt   = '{default: 4'd0};
        key_cnt    = '{default: 4'd0};
        cur_st     = azac_pkg::ST_DISARMED;
        req_st     = azac_pkg::ST_DISARMED;
        cause_zone = '0;
        siren_lvl  = 1'b0;
        blink_md   = azac_pkg::BLINK_OFF;
    endtask

    function automatic logic debounce_line(input logic first, input logic second,
                                           inout logic lvl, inout logic [3:0] cnt);
        logic [3:0] limit;
        limit = (thr_reg == 4'd0) ? 4'd1 : thr_reg;
        if (first == lvl)
            return 1'b0;
        if (second != lvl) begin
            if (cnt < 4'd15)
                cnt = cnt + 4'd1;
        end else begin
            cnt = 4'd0;
        end
        if (cnt >= limit) begin
            lvl = second;
            cnt = 4'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic azac_pkg::t_out_beat predict_status(input azac_pkg::t_in_beat b);
        azac_pkg::t_out_beat r;
        logic       moved;
        logic       entered;
        logic       beep;
        logic       notify;
        logic [2:0] fn;
        int         i;
        r = '0;
        moved = 1'b0;
        entered = 1'b0;
        beep = 1'b0;
        notify = 1'b0;
        if (b.command_valid && b.command_state <= azac_pkg::ST_TRIGGERED)
            req_st = azac_pkg::t_state'(b.command_state);
        for (i = 0; i < azac_pkg::NUM_ZONES_DEF; i++) begin
            if (debounce_line(b.zone_first[i], b.zone_second[i],
                              zone_lvl[i], zone_cnt[i])) begin
                moved = 1'b1;
                fn = zone_fn[3*i +: 3];
                if ((fn == azac_pkg::FN_PERIMETER &&
                     (cur_st == azac_pkg::ST_HOME || cur_st == azac_pkg::ST_AWAY)) ||
                    (fn == azac_pkg::FN_INTERIOR && cur_st == azac_pkg::ST_AWAY) ||
                    (fn == azac_pkg::FN_ALWAYS && zone_lvl[i])) begin
                    req_st = azac_pkg::ST_TRIGGERED;
                    cause_zone = 3'(i);
                end
            end
        end
        for (i = 0; i < azac_pkg::NUM_KEYS_DEF; i++) begin
            if (debounce_line(b.rf_first[i], b.rf_second[i], key_lvl[i], key_cnt[i])) begin
                moved = 1'b1;
                case (i)
                    azac_pkg::KEY_AWAY:   req_st = azac_pkg::ST_AWAY;
                    azac_pkg::KEY_HOME:   req_st = azac_pkg::ST_HOME;
                    azac_pkg::KEY_DISARM: req_st = azac_pkg::ST_DISARMED;
                    default:    ;
                endcase
            end
        end
        if (cur_st != req_st) begin
            entered = 1'b1;
            case (req_st)
                azac_pkg::ST_DISARMED: begin
                    siren_lvl = 1'b0;
                    blink_md = azac_pkg::BLINK_OFF;
                    if (cur_st == azac_pkg::ST_AWAY) begin
                        beep = 1'b1;
                        notify = 1'b1;
                    end
                end
                azac_pkg::ST_HOME: blink_md = azac_pkg::BLINK_SLOW;
                azac_pkg::ST_AWAY: begin
                    blink_md = azac_pkg::BLINK_SLOW;
                    beep = 1'b1;
                    notify = 1'b1;
                end
                azac_pkg::ST_TRIGGERED: begin
                    siren_lvl = 1'b1;
                    blink_md = azac_pkg::BLINK_FAST;
                    notify = 1'b1;
                end
                default: ;
            endcase
            cur_st = req_st;
        end
        r.alarm_state    = cur_st;
        r.trip_zone      = cause_zone;
        r.zone_levels    = zone_lvl;
        r.rf_levels      = key_lvl;
        r.siren_on       = siren_lvl;
        r.blink_mode     = blink_md;
        r.beep_pulse     = beep;
        r.notify_pulse   = notify;
        r.state_changed  = entered;
        r.inputs_changed = moved;
        return r;
    endfunction

    function automatic azac_pkg::t_in_beat make_beat(input logic [7:0] zf, zs,
                                                     input logic [3:0] kf, ks,
                                                     input logic cv, input logic [2:0] cs);
        azac_pkg::t_in_beat b;
        b = '0;
        b.zone_first    = zf;
        b.zone_second   = zs;
        b.rf_first      = kf;
        b.rf_second     = ks;
        b.command_valid = cv;
        b.command_state = cs;
        return b;
    endfunction

    // lines held at their debounced levels, so only the command acts
    function automatic azac_pkg::t_in_beat hold_beat(input logic cv, input logic [2:0] cs);
        return make_beat(zone_lvl, zone_lvl, key_lvl, key_lvl, cv, cs);
    endfunction

    task automatic send_tick(input azac_pkg::t_in_beat beat);
        if (!no_idle) begin
            while ($urandom_range(99) < 16) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_status.push_back(predict_status(beat));
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] rd;
        mask = (idx == azac_pkg::REG_ZONE_FN) ? 32'h00FF_FFFF : 32'h0000_000F;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == azac_pkg::REG_ZONE_FN)
            zone_fn = value[23:0];
        else
            thr_reg = value[3:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((rd & mask) !== (value & mask))
            report_mismatch("register readback", int'(rd & mask), int'(value & mask));
    endtask

    task automatic send_random_ticks(input int count);
        logic [7:0] zf;
        logic [7:0] zs;
        logic [3:0] kf;
        logic [3:0] ks;
        int         k;
        line_zone = zone_lvl;
        line_key  = key_lvl;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 8)
                line_zone = line_zone ^ (8'h01 << $urandom_range(7));
            if ($urandom_range(99) < 4)
                line_key = line_key ^ (4'h1 << $urandom_range(3));
            zf = line_zone;
            zs = line_zone;
            kf = line_key;
            ks = line_key;
            if ($urandom_range(99) < 10) begin
                zf = zf ^ 8'($urandom);
                kf = kf ^ 4'($urandom);
            end
            if ($urandom_range(99) < 5) begin
                zs = zs ^ 8'($urandom);
                ks = ks ^ 4'($urandom);
            end
            if ($urandom_range(99) < 8)
                {zf, zs, kf, ks} = 24'($urandom);
            send_tick(make_beat(zf, zs, kf, ks, ($urandom_range(99) < 6),
                                3'($urandom_range(7))));
        end
    endtask

    task automatic test_defaults();
        send_tick(make_beat(8'hFF, 8'hFF, 4'hF, 4'hF, 1'b0, azac_pkg::ST_DISARMED));
        send_tick(make_beat(8'hFF, 8'hFF, 4'hF, 4'hF, 1'b1, 3'd7));
        send_tick(make_beat(8'h00, 8'h00, 4'h0, 4'h0, 1'b0, 3'd7));
        send_tick(make_beat(8'h00, 8'hFF, 4'h0, 4'hF, 1'b0, azac_pkg::ST_DISARMED));
        drain();
    endtask

    task automatic test_commands();
        int s;
        for (s = 0; s < 8; s++)
            send_tick(hold_beat(1'b1, 3'(s)));
        send_tick(hold_beat(1'b1, azac_pkg::ST_DISARMED));
        send_tick(hold_beat(1'b1, azac_pkg::ST_AWAY));
        send_tick(hold_beat(1'b1, azac_pkg::ST_DISARMED));
        drain();
    endtask

    task automatic test_zone_actions();
        write_reg(azac_pkg::REG_ZONE_FN,
                  {8'h00, FN_SPARE_HI, FN_SPARE_MID, FN_SPARE_LO, azac_pkg::FN_DELAYED,
                   azac_pkg::FN_ALWAYS, azac_pkg::FN_INTERIOR, azac_pkg::FN_PERIMETER,
                   azac_pkg::FN_OFF});
        write_reg(azac_pkg::REG_THR, 32'd1);
        send_tick(hold_beat(1'b1, azac_pkg::ST_AWAY));
        send_tick(make_beat(8'h00, 8'h00, key_lvl, key_lvl, 1'b0, azac_pkg::ST_DISARMED));
        send_tick(hold_beat(1'b1, azac_pkg::ST_DISARMED));
        send_tick(make_beat(8'hFF, 8'hFF, key_lvl, key_lvl, 1'b0, azac_pkg::ST_DISARMED));
        send_tick(hold_beat(1'b1, azac_pkg::ST_HOME));
        send_tick(make_beat(8'h00, 8'h00, key_lvl, key_lvl, 1'b0, azac_pkg::ST_DISARMED));
        send_tick(hold_beat(1'b1, azac_pkg::ST_DISARMED));
        // key presses and releases both act
        send_tick(make_beat(zone_lvl, zone_lvl, 4'b1110, 4'b1110, 1'b0, azac_pkg::ST_DISARMED));
        send_tick(make_beat(zone_lvl, zone_lvl, 4'b1111, 4'b1111, 1'b0, azac_pkg::ST_DISARMED));
        send_tick(make_beat(zone_lvl, zone_lvl, 4'b1011, 4'b1011, 1'b0, azac_pkg::ST_DISARMED));
        send_tick(make_beat(zone_lvl, zone_lvl, 4'b1001, 4'b1001, 1'b0, azac_pkg::ST_DISARMED));
        send_tick(make_beat(zone_lvl, zone_lvl, 4'b0001, 4'b0001, 1'b0, azac_pkg::ST_DISARMED));
        send_tick(make_beat(zone_lvl, zone_lvl, 4'b1111, 4'b1111, 1'b0, azac_pkg::ST_DISARMED));
        // key overrides a command in the same tick
        send_tick(make_beat(zone_lvl, zone_lvl, 4'b1110, 4'b1110, 1'b1, azac_pkg::ST_HOME));
        send_tick(make_beat(zone_lvl, zone_lvl, 4'b1111, 4'b1111, 1'b1, azac_pkg::ST_DISARMED));
        drain();
    endtask

    task automatic test_random_phases();
        logic [31:0] fn;
        logic [3:0]  thr;
        int          p;
        int          z;
        for (p = 0; p < 8; p++) begin
            drain();
            fn = '0;
            for (z = 0; z < azac_pkg::NUM_ZONES_DEF; z++)
                fn[3*z +: 3] = 3'($urandom_range(4));
            case (p)
                0: begin fn = 32'h00FF_FFFF; thr = 4'd1; end
                1: begin fn = 32'h0;         thr = 4'd15; end
                2: thr = 4'd0;
                3: thr = 4'd2;
                4: begin fn = $urandom;      thr = 4'd3; end
                5: thr = azac_pkg::THR_RESET;
                6: thr = 4'($urandom_range(1, 15));
                default: begin fn = $urandom; thr = 4'd1; end
            endcase
            write_reg(azac_pkg::REG_ZONE_FN, fn);
            write_reg(azac_pkg::REG_THR, {28'd0, thr});
            no_idle <= (p == 3);
            send_random_ticks(160);
        end
        no_idle <= 1'b0;
    endtask

    task automatic test_backpressure();
        drain();
        write_reg(azac_pkg::REG_THR, 32'd2);
        no_idle <= 1'b1;
        -> hold_out;
        send_random_ticks(40);
        drain();
        send_random_ticks(30);
        no_idle <= 1'b0;
    endtask

    always begin
        @(hold_out);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_active)
            m_axis_tready <= 1'b0;
        else if (no_idle)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 16);
    end

    always @(posedge i_clk) begin : check_status
        azac_pkg::t_out_beat got;
        azac_pkg::t_out_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = azac_pkg::t_out_beat'(m_axis_tdata);
            if (expected_status.size() == 0) begin
                report_mismatch("status beat with nothing pending", 1, 0);
            end else begin
                want = expected_status.pop_front();
                if (got.alarm_state !== want.alarm_state)
                    report_mismatch("alarm_state", got.alarm_state, want.alarm_state);
                if (got.trip_zone !== want.trip_zone)
                    report_mismatch("trip_zone", got.trip_zone, want.trip_zone);
                if (got.zone_levels !== want.zone_levels)
                    report_mismatch("zone_levels", got.zone_levels, want.zone_levels);
                if (got.rf_levels !== want.rf_levels)
                    report_mismatch("rf_levels", got.rf_levels, want.rf_levels);
                if (got.siren_on !== want.siren_on)
                    report_mismatch("siren_on", got.siren_on, want.siren_on);
                if (got.blink_mode !== want.blink_mode)
                    report_mismatch("blink_mode", got.blink_mode, want.blink_mode);
                if (got.beep_pulse !== want.beep_pulse)
                    report_mismatch("beep_pulse", got.beep_pulse, want.beep_pulse);
                if (got.notify_pulse !== want.notify_pulse)
                    report_mismatch("notify_pulse", got.notify_pulse, want.notify_pulse);
                if (got.state_changed !== want.state_changed)
                    report_mismatch("state_changed", got.state_changed, want.state_changed);
                if (got.inputs_changed !== want.inputs_changed)
                    report_mismatch("inputs_changed", got.inputs_changed, want.inputs_changed);
            end
        end
    end

    initial begin
        model_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_commands();
        test_zone_actions();
        test_random_phases();
        test_backpressure();
        drain();
        if (expected_status.size() != 0)
            report_mismatch("status beats never returned", 0, expected_status.size());
        if (mismatches == 0)
            $display("[alarm_zone_arming_controller_core] OK");
        else
            $display("[alarm_zone_arming_controller_core] ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[alarm_zone_arming_controller_core] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/azac_pkg.sv
design/azac_lane.sv
design/azac_merge.sv
design/alarm_zone_arming_controller_core.sv
tb/alarm_zone_arming_controller_core_test.sv
